>>> src/mpss_pkg.sv
// Shared types and constants for the multi-pattern site scanner.
package mpss_pkg;

  localparam int SYM_W     = 8;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int CNT_W     = 3;
  localparam int OFF_W     = 6;
  localparam int POS_W     = 33;
  localparam int MCOUNT_W  = 31;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 4;

  localparam int DEF_MAX_PATTERN_LEN = 8;
  localparam int DEF_MAX_PATTERNS    = 4;
  localparam int DEF_INDEX_BITS      = 31;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_OFFSET = 3'd6;

  localparam logic [PAT_W-1:0] PATTERN_0_RESET      = 64'h6761;
  localparam logic [PAT_W-1:0] PATTERN_RESET        = '0;
  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 4'd2;
  localparam logic [CNT_W-1:0] PATTERN_COUNT_RESET  = 3'd1;
  localparam logic [OFF_W-1:0] OFFSET_RESET         = '0;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             end_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    is_match;
    logic                    end_flag;
    logic [MCOUNT_W-1:0]     match_count;
  } out_item_t;

  // Entry between front and back: start position before the offset is added
  typedef struct packed {
    logic [POS_W-1:0]    base_pos;
    logic                is_match;
    logic                end_flag;
    logic [MCOUNT_W-1:0] match_count;
  } q_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] pattern_length;
    logic [CNT_W-1:0] pattern_count;
  } scan_cfg_t;

endpackage

>>> src/mpss_front.sv
// Front end: byte window, parallel pattern compare, sequence counters.
module mpss_front #(
  parameter int MAX_PATTERN_LEN = mpss_pkg::DEF_MAX_PATTERN_LEN,
  parameter int MAX_PATTERNS    = mpss_pkg::DEF_MAX_PATTERNS,
  parameter int INDEX_BITS      = mpss_pkg::DEF_INDEX_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  mpss_pkg::in_item_t        item,
  input  logic [mpss_pkg::PAT_W-1:0] pattern [MAX_PATTERNS],
  input  mpss_pkg::scan_cfg_t       cfg,
  output logic                      q_wr,
  output mpss_pkg::q_item_t         q_data
);
  import mpss_pkg::*;

  localparam int WIN_D  = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1;
  localparam int FILL_W = $clog2(MAX_PATTERN_LEN + 1);
  localparam int BW     = ((INDEX_BITS > POS_W) ? INDEX_BITS : POS_W) + 1;

  logic [SYM_W-1:0]      win_r [WIN_D];
  logic [SYM_W-1:0]      win_nxt [WIN_D];
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [INDEX_BITS-1:0] index_r, index_nxt;
  logic [MCOUNT_W-1:0]   found_r, found_nxt;

  logic [SYM_W-1:0]        cur [MAX_PATTERN_LEN];
  logic [MAX_PATTERNS-1:0] lane_eq [MAX_PATTERN_LEN];
  logic [MAX_PATTERNS-1:0] lane_sel, lane_use;
  logic [LEN_W-1:0]        len_eff;
  logic [CNT_W-1:0]        cnt_eff;
  logic                    enough, match;
  logic [BW-1:0]           base_w;

  always_comb begin
    priority if (cfg.pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN_LEN)) begin
      len_eff = LEN_W'(MAX_PATTERN_LEN);
    end else begin
      len_eff = cfg.pattern_length;
    end
    if (cfg.pattern_count > CNT_W'(MAX_PATTERNS)) begin
      cnt_eff = CNT_W'(MAX_PATTERNS);
    end else begin
      cnt_eff = cfg.pattern_count;
    end
  end

  // Window ending at the current byte, most recent first
  always_comb begin
    cur[0] = item.symbol;
    for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
      cur[i] = win_r[i-1];
    end
  end

  // One compare set per possible length; pattern byte 0 meets the oldest byte
  always_comb begin
    for (int l = 0; l < MAX_PATTERN_LEN; l++) begin
      for (int c = 0; c < MAX_PATTERNS; c++) begin
        lane_eq[l][c] = 1'b1;
        for (int i = 0; i <= l; i++) begin
          if (cur[i] != pattern[c][SYM_W*(l-i) +: SYM_W]) begin
            lane_eq[l][c] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    lane_sel = '0;
    for (int l = 0; l < MAX_PATTERN_LEN; l++) begin
      if (len_eff == LEN_W'(l + 1)) begin
        lane_sel = lane_eq[l];
      end
    end
    for (int c = 0; c < MAX_PATTERNS; c++) begin
      lane_use[c] = (CNT_W'(c) < cnt_eff);
    end
    enough = ((LEN_W+1)'(fill_r) + (LEN_W+1)'(1)) >= (LEN_W+1)'(len_eff);
    match  = enough && ((lane_sel & lane_use) != '0);
  end

  always_comb begin
    found_nxt = found_r;
    if (match && (found_r != '1)) begin
      found_nxt = found_r + MCOUNT_W'(1);
    end
    base_w = BW'(index_r) - BW'(len_eff) + BW'(2);

    q_wr                 = accept && (match || item.end_of_sequence);
    q_data.base_pos      = base_w[POS_W-1:0];
    q_data.is_match      = match;
    q_data.end_flag      = item.end_of_sequence;
    q_data.match_count   = found_nxt;
  end

  always_comb begin
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    index_nxt = index_r;
    if (accept) begin
      if (item.end_of_sequence) begin
        for (int k = 0; k < WIN_D; k++) begin
          win_nxt[k] = '0;
        end
        fill_nxt  = '0;
        index_nxt = '0;
      end else begin
        for (int k = WIN_D - 1; k > 0; k--) begin
          win_nxt[k] = win_r[k-1];
        end
        win_nxt[0] = item.symbol;
        if (fill_r < FILL_W'(MAX_PATTERN_LEN - 1)) begin
          fill_nxt = fill_r + FILL_W'(1);
        end
        if (index_r != '1) begin
          index_nxt = index_r + INDEX_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN_D; k++) begin
        win_r[k] <= '0;
      end
      fill_r  <= '0;
      index_r <= '0;
      found_r <= '0;
    end else begin
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      index_r <= index_nxt;
      if (accept) begin
        found_r <= item.end_of_sequence ? '0 : found_nxt;
      end
    end
  end

endmodule

>>> src/mpss_queue.sv
// Short result queue between the front end and the output stage.
module mpss_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  mpss_pkg::q_item_t wr_data,
  input  logic              rd,
  output mpss_pkg::q_item_t rd_data,
  output logic              full,
  output logic              empty
);
  import mpss_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_QW = $clog2(QDEPTH + 1);

  q_item_t           slot_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;
  logic              do_wr, do_rd;

  assign full    = (count_r == CNT_QW'(QDEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slot_r[rd_ptr_r];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_QW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> src/mpss_back.sv
// Back end: applies the position offset and holds the result register.
module mpss_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  mpss_pkg::q_item_t           q_data,
  output logic                        q_rd,
  input  logic [mpss_pkg::OFF_W-1:0]  offset,
  input  logic                        out_pop,
  output logic                        out_empty,
  output mpss_pkg::out_item_t         out_item
);
  import mpss_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t item_r, item_nxt;
  logic      load;

  assign out_empty = !valid_r;
  assign out_item  = item_r;
  // Advance when the register is free or its item leaves this cycle
  assign load      = !q_empty && (!valid_r || out_pop);
  assign q_rd      = load;

  always_comb begin
    item_nxt.position    = q_data.is_match
                         ? $signed(q_data.base_pos + {{(POS_W-OFF_W){offset[OFF_W-1]}}, offset})
                         : '0;
    item_nxt.is_match    = q_data.is_match;
    item_nxt.end_flag    = q_data.end_flag;
    item_nxt.match_count = q_data.match_count;

    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

>>> src/multi_pattern_site_scanner_core.sv
// Each result is written to the queue, then loaded into the output register.
// One byte per cycle while in_full is low; all lanes compare in the same cycle.
// A four-entry queue and the output register let input and output stall apart;
// in_full rises only when both are full.
// Reset (synchronous, rst_n low) loads the register defaults and clears the
// window, counters, queue and output register.
module multi_pattern_site_scanner_core #(
  parameter int MAX_PATTERN_LEN = mpss_pkg::DEF_MAX_PATTERN_LEN,
  parameter int MAX_PATTERNS    = mpss_pkg::DEF_MAX_PATTERNS,
  parameter int INDEX_BITS      = mpss_pkg::DEF_INDEX_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  mpss_pkg::in_item_t             in_item,
  output logic                           out_empty,
  input  logic                           out_pop,
  output mpss_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [mpss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpss_pkg::PAT_W-1:0]     cfg_data
);
  import mpss_pkg::*;

  logic [PAT_W-1:0] pattern_r [MAX_PATTERNS];
  logic [LEN_W-1:0] length_r;
  logic [CNT_W-1:0] count_r;
  logic [OFF_W-1:0] offset_r;
  scan_cfg_t        scan_cfg;

  logic    accept;
  logic    q_wr, q_rd, q_full, q_empty;
  q_item_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < MAX_PATTERNS; c++) begin
        pattern_r[c] <= (c == 0) ? PATTERN_0_RESET : PATTERN_RESET;
      end
      length_r <= PATTERN_LENGTH_RESET;
      count_r  <= PATTERN_COUNT_RESET;
      offset_r <= OFFSET_RESET;
    end else if (cfg_we) begin
      for (int c = 0; c < MAX_PATTERNS; c++) begin
        if (cfg_index == REG_PATTERN_0 + CFG_IDX_W'(c)) begin
          pattern_r[c] <= cfg_data;
        end
      end
      if (cfg_index == REG_PATTERN_LENGTH) begin
        length_r <= cfg_data[LEN_W-1:0];
      end
      if (cfg_index == REG_PATTERN_COUNT) begin
        count_r <= cfg_data[CNT_W-1:0];
      end
      if (cfg_index == REG_POSITION_OFFSET) begin
        offset_r <= cfg_data[OFF_W-1:0];
      end
    end
  end

  assign scan_cfg.pattern_length = length_r;
  assign scan_cfg.pattern_count  = count_r;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  mpss_front #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .MAX_PATTERNS    (MAX_PATTERNS),
    .INDEX_BITS      (INDEX_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_item),
    .pattern (pattern_r),
    .cfg     (scan_cfg),
    .q_wr    (q_wr),
    .q_data  (q_wdata)
  );

  mpss_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wdata),
    .rd      (q_rd),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  mpss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_rd      (q_rd),
    .offset    (offset_r),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

>>> sim/multi_pattern_site_scanner_core_tb.sv
`timescale 1ns / 1ps
// Testbench for multi_pattern_site_scanner_core: a directed table, then randomized scans.
module multi_pattern_site_scanner_core_tb;
  import mpss_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1 = REG_PATTERN_0 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 3'd7;

  localparam int     WIN_DEPTH     = DEF_MAX_PATTERN_LEN - 1;
  localparam longint INDEX_MAX     = (longint'(1) << DEF_INDEX_BITS) - 1;
  localparam longint COUNT_MAX     = (longint'(1) << MCOUNT_W) - 1;
  localparam int     SETTLE_CYCLES = 4;
  localparam int     DRAIN_CYCLES  = 8;
  localparam int     STALL_LIMIT   = 2000;
  localparam int     LONG_HOLD     = 80;
  localparam int     NUM_PHASES    = 14;
  localparam int     PHASE_ITEMS   = 50;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [PAT_W-1:0]     data;
    in_item_t             item;
    bit                   typed;
    out_item_t            want;
  } dir_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_push   = 1'b0;
  logic                 in_full;
  in_item_t             in_item   = '0;
  logic                 out_empty;
  logic                 out_pop   = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PAT_W-1:0]     cfg_data  = '0;

  // Scanner mirror: configuration and per-sequence state
  logic [PAT_W-1:0] pat_reg [4];
  logic [LEN_W-1:0] pat_len_reg;
  logic [CNT_W-1:0] pat_cnt_reg;
  logic [OFF_W-1:0] pos_off_reg;
  logic [SYM_W-1:0] win_bytes [WIN_DEPTH];
  int               win_fill;
  longint           seq_index;
  longint           hit_total;

  out_item_t        site_reports_q[$];
  logic [SYM_W-1:0] pend_bytes[$];
  dir_row_t         dir_rows[$];
  out_item_t        want_rep;
  int               errors      = 0;
  int               idle_cycles = 0;
  int               hold_left   = 0;
  bit               hold_done   = 1'b0;
  bit               hold_ask    = 1'b0;
  bit               quiet       = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_pattern_site_scanner_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic dir_row_t rep_row(logic [SYM_W-1:0] sym, bit eos, bit hit, longint pos,
                                       longint cnt);
    dir_row_t r;
    r.is_cfg                 = 1'b0;
    r.idx                    = '0;
    r.data                   = '0;
    r.item.symbol            = sym;
    r.item.end_of_sequence   = eos;
    r.typed                  = 1'b1;
    r.want.position          = pos[POS_W-1:0];
    r.want.is_match          = hit;
    r.want.end_flag          = eos;
    r.want.match_count       = cnt[MCOUNT_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t sym_row(logic [SYM_W-1:0] sym, bit eos);
    dir_row_t r;
    r       = rep_row(sym, eos, 1'b0, 0, 0);
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [PAT_W-1:0] data);
    dir_row_t r;
    r        = sym_row(8'h00, 1'b0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic int eff_len();
    if (pat_len_reg == 0) return 1;
    if (pat_len_reg > DEF_MAX_PATTERN_LEN) return DEF_MAX_PATTERN_LEN;
    return int'(pat_len_reg);
  endfunction

  function automatic int eff_cnt();
    if (pat_cnt_reg > DEF_MAX_PATTERNS) return DEF_MAX_PATTERNS;
    return int'(pat_cnt_reg);
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol();
    case ($urandom_range(0, 4))
      0: return "a";
      1: return "c";
      2: return "g";
      3: return "t";
      default: return SYM_W'($urandom_range(0, 255));
    endcase
  endfunction

  function void clear_window();
    foreach (win_bytes[k]) win_bytes[k] = '0;
    win_fill  = 0;
    seq_index = 0;
    hit_total = 0;
  endfunction

  // Compare the window ending at this byte against every live pattern
  task automatic predict_site_report(input in_item_t it, output bit produced,
                                     output out_item_t rep);
    int               len;
    int               cnt;
    bit               hit;
    bit               ok;
    longint           off_v;
    longint           p;
    logic [SYM_W-1:0] wb;
    len = eff_len();
    cnt = eff_cnt();
    hit = 1'b0;
    if (win_fill + 1 >= len) begin
      for (int c = 0; c < cnt; c++) begin
        ok = 1'b1;
        for (int j = 0; j < len; j++) begin
          wb = (j == len - 1) ? it.symbol : win_bytes[len - 2 - j];
          if (wb != pat_reg[c][8*j +: 8]) ok = 1'b0;
        end
        hit |= ok;
      end
    end
    if (hit && hit_total < COUNT_MAX) hit_total++;
    produced = hit || it.end_of_sequence;
    rep      = '0;
    if (hit) begin
      off_v        = $signed(pos_off_reg);
      p            = seq_index - len + 2 + off_v;
      rep.position = p[POS_W-1:0];
    end
    rep.is_match    = hit;
    rep.end_flag    = it.end_of_sequence;
    rep.match_count = hit_total[MCOUNT_W-1:0];
    if (it.end_of_sequence) begin
      clear_window();
    end else begin
      for (int k = WIN_DEPTH - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
      win_bytes[0] = it.symbol;
      if (win_fill < WIN_DEPTH) win_fill++;
      if (seq_index < INDEX_MAX) seq_index++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx < REG_PATTERN_LENGTH) pat_reg[2'(idx - REG_PATTERN_0)] = data;
    else if (idx == REG_PATTERN_LENGTH) pat_len_reg = data[LEN_W-1:0];
    else if (idx == REG_PATTERN_COUNT) pat_cnt_reg = data[CNT_W-1:0];
    else if (idx == REG_POSITION_OFFSET) pos_off_reg = data[OFF_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop pushing, drain all expected results, then let the pipeline sit idle
  task automatic settle();
    in_push <= 1'b0;
    while (site_reports_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic push_symbol(input in_item_t it, input bit typed, input out_item_t want);
    bit        produced;
    out_item_t rep;
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    predict_site_report(it, produced, rep);
    if (typed) site_reports_q.push_back(want);
    else if (produced) site_reports_q.push_back(rep);
  endtask

  // Whole pattern copies, picked with bias percent odds, broken up by noise bytes and early sequence ends
  task automatic next_symbol(input int bias, output in_item_t it);
    int len;
    int cnt;
    int c;
    len = eff_len();
    cnt = eff_cnt();
    if (pend_bytes.size() == 0) begin
      if (cnt > 0 && $urandom_range(0, 99) < bias) begin
        c = $urandom_range(0, cnt - 1);
        for (int j = 0; j < len; j++) pend_bytes.push_back(pat_reg[c][8*j +: 8]);
      end else begin
        repeat ($urandom_range(1, 3)) pend_bytes.push_back(pick_symbol());
      end
    end
    it.symbol          = pend_bytes.pop_front();
    it.end_of_sequence = ($urandom_range(0, 29) == 0);
  endtask

  task automatic load_phase_cfg(input int ph);
    logic [PAT_W-1:0] pv;
    logic [PAT_W-1:0] len_v;
    logic [PAT_W-1:0] cnt_v;
    logic [PAT_W-1:0] off_v;
    for (int n = 0; n < 4; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        pv = {$urandom, $urandom};
      end else begin
        for (int b = 0; b < 8; b++) pv[8*b +: 8] = pick_symbol();
      end
      write_reg(REG_PATTERN_0 + CFG_IDX_W'(n), pv);
    end
    case (ph)
      0: begin
        len_v = PAT_W'(DEF_MAX_PATTERN_LEN);
        cnt_v = PAT_W'(DEF_MAX_PATTERNS);
        off_v = 64'h30;
      end
      1: begin
        len_v = 64'd1;
        cnt_v = 64'd1;
        off_v = 64'd16;
      end
      default: begin
        len_v = PAT_W'(($urandom_range(0, 5) == 0) ? $urandom_range(9, 16) % 16
                                                    : $urandom_range(1, 8));
        cnt_v = PAT_W'(($urandom_range(0, 5) == 0) ? $urandom_range(5, 8) % 8
                                                    : $urandom_range(1, 4));
        off_v = PAT_W'($urandom_range(0, 63));
      end
    endcase
    write_reg(REG_PATTERN_LENGTH, len_v);
    write_reg(REG_PATTERN_COUNT, cnt_v);
    write_reg(REG_POSITION_OFFSET, off_v);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
  endtask

  // Result side: check each popped item, then pick next cycle's pop
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (site_reports_q.size() == 0) begin
        $error("unexpected result: position %0d, is_match %0b, end_flag %0b, match_count %0d",
               $signed(out_item.position), out_item.is_match, out_item.end_flag,
               out_item.match_count);
        errors++;
      end else begin
        want_rep = site_reports_q.pop_front();
        if (out_item.position !== want_rep.position) begin
          $error("position: expected %0d, got %0d", $signed(want_rep.position),
                 $signed(out_item.position));
          errors++;
        end
        if (out_item.is_match !== want_rep.is_match) begin
          $error("is_match: expected %0b, got %0b", want_rep.is_match, out_item.is_match);
          errors++;
        end
        if (out_item.end_flag !== want_rep.end_flag) begin
          $error("end_flag: expected %0b, got %0b", want_rep.end_flag, out_item.end_flag);
          errors++;
        end
        if (out_item.match_count !== want_rep.match_count) begin
          $error("match_count: expected %0d, got %0d", want_rep.match_count,
                 out_item.match_count);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (hold_ask && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(1, 9) - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    pat_reg[0]  = PATTERN_0_RESET;
    pat_reg[1]  = PATTERN_RESET;
    pat_reg[2]  = PATTERN_RESET;
    pat_reg[3]  = PATTERN_RESET;
    pat_len_reg = PATTERN_LENGTH_RESET;
    pat_cnt_reg = PATTERN_COUNT_RESET;
    pos_off_reg = OFFSET_RESET;
    clear_window();

    dir_rows = '{
      // reset settings: one pattern "ag", two bytes, no offset
      sym_row("a", 1'b0),
      rep_row("g", 1'b0, 1'b1, 1, 1),
      sym_row("a", 1'b0),
      rep_row("g", 1'b1, 1'b1, 3, 2),
      rep_row(8'hFF, 1'b1, 1'b0, 0, 0),
      rep_row(8'h00, 1'b1, 1'b0, 0, 0),
      // all-zero pattern: the cleared window must not match before three bytes
      cfg_row(REG_PATTERN_0, 64'h0),
      cfg_row(REG_PATTERN_LENGTH, 64'd3),
      cfg_row(REG_POSITION_OFFSET, 64'h30),
      sym_row(8'h00, 1'b0),
      sym_row(8'h00, 1'b0),
      rep_row(8'h00, 1'b1, 1'b1, -15, 1),
      // oversized length and count clamp; offset beyond sixteen applies as given
      cfg_row(REG_PATTERN_1, 64'hFFFF_FFFF_FFFF_FFFF),
      cfg_row(REG_PATTERN_COUNT, 64'd7),
      cfg_row(REG_PATTERN_LENGTH, 64'd15),
      cfg_row(REG_POSITION_OFFSET, 64'h1F),
      sym_row(8'hFF, 1'b0),
      sym_row(8'hFF, 1'b0),
      sym_row(8'hFF, 1'b0),
      sym_row(8'hFF, 1'b0),
      sym_row(8'hFF, 1'b0),
      sym_row(8'hFF, 1'b0),
      sym_row(8'hFF, 1'b0),
      rep_row(8'hFF, 1'b1, 1'b1, 32, 1),
      // zero length acts as one; zero count disables every pattern
      cfg_row(REG_PATTERN_LENGTH, 64'd0),
      cfg_row(REG_PATTERN_COUNT, 64'd0),
      rep_row(8'h78, 1'b1, 1'b0, 0, 0),
      cfg_row(REG_PATTERN_COUNT, 64'd2),
      rep_row(8'hFF, 1'b0, 1'b1, 32, 1),
      rep_row(8'h00, 1'b1, 1'b1, 33, 2),
      // a write past the register list changes nothing
      cfg_row(REG_UNUSED, 64'h0),
      rep_row(8'hFF, 1'b1, 1'b1, 32, 1)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        settle();
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        sender_gap();
        push_symbol(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      pend_bytes.delete();
      load_phase_cfg(ph);
      if (ph >= NUM_PHASES - 2) quiet <= 1'b1;
      // single-byte pattern, every byte a hit: fill the block while the receiver holds
      if (ph == 1) hold_ask <= 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 5 && i == PHASE_ITEMS / 2) begin
          in_push <= 1'b0;
          do @(posedge clk); while (site_reports_q.size() != 0);
        end
        sender_gap();
        next_symbol((ph == 1) ? 100 : 40, it);
        push_symbol(it, 1'b0, '0);
      end
    end

    in_push <= 1'b0;
    while (site_reports_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (site_reports_q.size() != 0) begin
      $error("%0d expected results never arrived", site_reports_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
